>>> design/cds_pkg.sv
package cds_pkg;

    // Default width of the stored year
    localparam int unsigned YEAR_BITS_DEF = 16;

    // Date after reset
    localparam int unsigned RESET_DAY   = 1;
    localparam int unsigned RESET_MONTH = 1;
    localparam int unsigned RESET_YEAR  = 1970;

    // Leap-year cycle length and calendar limits
    localparam int unsigned LEAP_CYCLE  = 400;
    localparam int unsigned MONTHS      = 12;
    localparam int unsigned LONG_MONTH  = 31;

    // Width of a remainder modulo the leap-year cycle
    localparam int unsigned MOD_BITS    = 9;

    typedef enum logic [1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_SHIFT   = 2'd1,
        FUNC_COMPARE = 2'd2,
        FUNC_NONE    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ORD_EQUAL   = 2'd0,
        ORD_EARLIER = 2'd1,
        ORD_LATER   = 2'd2
    } t_order;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CLAMP,
        ST_STEP,
        ST_RESP
    } t_state;

    // Leap year from the year modulo 400: divisible by 4, except the
    // century years that are not a multiple of 400
    function automatic logic leap_of(input logic [MOD_BITS-1:0] m400);
        logic leap;
        leap = (m400[1:0] == 2'd0) && (m400 != MOD_BITS'(100))
            && (m400 != MOD_BITS'(200)) && (m400 != MOD_BITS'(300));
        return leap;
    endfunction

    // Number of days in a month
    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

>>> design/calendar_date_stepper_core.sv
// Calendar date stepper. Holds one Gregorian date (1/1/1970 after reset) and
// takes one command word when start is high and busy is low. A load clamps
// the given date to a valid one, passing through REDUCE, which takes the year
// modulo 400 for its leap status (a reciprocal multiply, then the remainder),
// then CLAMP and then RESP, which presents the word. A shift walks one day per
// cycle in STEP until |day_delta| days are walked, then goes to RESP. A
// compare, and the unused code, go straight to RESP. Each command ends with
// o_valid high for exactly one cycle together with the date after the command
// and the order code (nonzero only for compare); the word must be taken in
// that cycle, since the block cannot be held off. A new command may be started
// in the cycle that o_valid is high.
module calendar_date_stepper_core #(
    parameter int unsigned YEAR_BITS = cds_pkg::YEAR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [4:0]  i_in_day,
    input  logic [3:0]  i_in_month,
    input  logic [15:0] i_in_year,
    input  logic signed [15:0] i_day_delta,
    output logic        o_valid,
    output logic [4:0]  o_cur_day,
    output logic [3:0]  o_cur_month,
    output logic [15:0] o_cur_year,
    output logic [1:0]  o_order
);

    localparam int unsigned MB  = cds_pkg::MOD_BITS;
    localparam int unsigned CW  = (YEAR_BITS > 16) ? YEAR_BITS : 16;
    // Year above its low four bits is reduced modulo 25 (400 = 16 * 25)
    localparam int unsigned XB  = YEAR_BITS - 4;
    localparam int unsigned SH  = XB + 5;
    localparam logic [XB:0] RECIP = (XB+1)'(((64'd1 << SH) + 64'd24) / 64'd25);
    localparam logic [MB-1:0] LAST_MOD   = MB'(cds_pkg::LEAP_CYCLE - 1);
    localparam logic [MB-1:0] MAX_MOD    =
        MB'(((64'd1 << YEAR_BITS) - 64'd1) % 64'(cds_pkg::LEAP_CYCLE));
    localparam logic [MB-1:0] RESET_MOD  =
        MB'((cds_pkg::RESET_YEAR % (64'd1 << YEAR_BITS)) % cds_pkg::LEAP_CYCLE);
    localparam logic [YEAR_BITS-1:0] MAX_YEAR = '1;

    cds_pkg::t_state r_state, n_state;

    logic [4:0]           r_day;
    logic [3:0]           r_month;
    logic [YEAR_BITS-1:0] r_year;
    logic [MB-1:0]        r_m400;
    logic [1:0]           r_order;

    logic [15:0]          r_cnt;
    logic                 r_back;
    logic [4:0]           r_ld_day;
    logic [3:0]           r_ld_month;
    logic [YEAR_BITS-1:0] r_ld_year;
    logic [MB-1:0]        r_rem;
    logic [2*XB:0]        r_prod;
    logic                 r_mul_done;

    cds_pkg::t_func       w_func;
    logic [CW-1:0]        w_in_year_ext;
    logic [CW-1:0]        w_year_ext;
    logic [3:0]           w_ld_month;
    logic                 w_leap;
    logic [4:0]           w_mdays_cur;
    logic [3:0]           w_month_prev;
    logic [4:0]           w_mdays_prev;
    logic [2*XB:0]        w_prod;
    logic [XB-5:0]        w_quot;
    logic [XB-1:0]        w_q25;
    logic [4:0]           w_rem25;
    logic [MB-1:0]        w_m400;
    logic [4:0]           w_ld_len;
    logic [1:0]           w_cmp;
    logic                 w_accept;

    assign w_func        = cds_pkg::t_func'(i_func);
    assign w_accept      = start && !busy;
    assign w_in_year_ext = CW'(i_in_year);
    assign w_year_ext    = CW'(r_year);

    // Clamp the given month into 1..12
    always_comb begin
        if (i_in_month == 4'd0) begin
            w_ld_month = 4'd1;
        end else if (i_in_month > 4'(cds_pkg::MONTHS)) begin
            w_ld_month = 4'(cds_pkg::MONTHS);
        end else begin
            w_ld_month = i_in_month;
        end
    end

    // Month lengths around the stored date
    assign w_leap       = cds_pkg::leap_of(r_m400);
    assign w_mdays_cur  = cds_pkg::month_days(r_month, w_leap);
    assign w_month_prev = r_month - 4'd1;
    assign w_mdays_prev = cds_pkg::month_days(w_month_prev, w_leap);

    // Year modulo 400: quotient by 25 from a reciprocal multiply, then the
    // remainder by 25 joined with the low four bits of the year
    assign w_prod    = (2*XB+1)'(r_ld_year[YEAR_BITS-1:4]) * (2*XB+1)'(RECIP);
    assign w_quot    = r_prod[2*XB:SH];
    // quotient times 25 as 16 + 8 + 1
    assign w_q25     = {w_quot, 4'b0000} + {1'b0, w_quot, 3'b000} + {4'b0000, w_quot};
    assign w_rem25   = 5'(r_ld_year[YEAR_BITS-1:4] - w_q25);
    assign w_m400    = {w_rem25, r_ld_year[3:0]};
    assign w_ld_len  = cds_pkg::month_days(r_ld_month, cds_pkg::leap_of(r_rem));

    // Order the stored date against the given one: year, month, day
    always_comb begin
        if (w_year_ext != w_in_year_ext) begin
            w_cmp = (w_year_ext < w_in_year_ext) ? cds_pkg::ORD_EARLIER : cds_pkg::ORD_LATER;
        end else if (r_month != i_in_month) begin
            w_cmp = (r_month < i_in_month) ? cds_pkg::ORD_EARLIER : cds_pkg::ORD_LATER;
        end else if (r_day != i_in_day) begin
            w_cmp = (r_day < i_in_day) ? cds_pkg::ORD_EARLIER : cds_pkg::ORD_LATER;
        end else begin
            w_cmp = cds_pkg::ORD_EQUAL;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cds_pkg::ST_IDLE, cds_pkg::ST_RESP: begin
                if (start) begin
                    unique case (w_func)
                        cds_pkg::FUNC_LOAD:  n_state = cds_pkg::ST_REDUCE;
                        cds_pkg::FUNC_SHIFT: n_state = cds_pkg::ST_STEP;
                        cds_pkg::FUNC_COMPARE, cds_pkg::FUNC_NONE:
                                             n_state = cds_pkg::ST_RESP;
                    endcase
                end else begin
                    n_state = cds_pkg::ST_IDLE;
                end
            end
            cds_pkg::ST_REDUCE: begin
                if (r_mul_done) begin
                    n_state = cds_pkg::ST_CLAMP;
                end
            end
            cds_pkg::ST_CLAMP: n_state = cds_pkg::ST_RESP;
            cds_pkg::ST_STEP: begin
                if (r_cnt == 16'd0) begin
                    n_state = cds_pkg::ST_RESP;
                end
            end
            default: n_state = cds_pkg::ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        busy    = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            cds_pkg::ST_IDLE: busy = 1'b0;
            cds_pkg::ST_RESP: begin
                busy    = 1'b0;
                o_valid = 1'b1;
            end
            cds_pkg::ST_REDUCE, cds_pkg::ST_CLAMP, cds_pkg::ST_STEP: busy = 1'b1;
            default: busy = 1'b1;
        endcase
    end

    assign o_cur_day   = r_day;
    assign o_cur_month = r_month;
    assign o_cur_year  = w_year_ext[15:0];
    assign o_order     = r_order;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cds_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Stored date and its year modulo 400
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day   <= 5'(cds_pkg::RESET_DAY);
            r_month <= 4'(cds_pkg::RESET_MONTH);
            r_year  <= YEAR_BITS'(cds_pkg::RESET_YEAR);
            r_m400  <= RESET_MOD;
            r_order <= cds_pkg::ORD_EQUAL;
        end else begin
            // latch the order on every accepted word
            if (w_accept) begin
                r_order <= (w_func == cds_pkg::FUNC_COMPARE) ? w_cmp : cds_pkg::ORD_EQUAL;
            end

            // store the clamped load date
            if (r_state == cds_pkg::ST_CLAMP) begin
                r_month <= r_ld_month;
                r_year  <= r_ld_year;
                r_m400  <= r_rem;
                if (r_ld_day == 5'd0) begin
                    r_day <= 5'd1;
                end else if (r_ld_day > w_ld_len) begin
                    r_day <= w_ld_len;
                end else begin
                    r_day <= r_ld_day;
                end
            end

            // advance or step back one day
            if (r_state == cds_pkg::ST_STEP && r_cnt != 16'd0) begin
                if (!r_back) begin
                    if (r_month == 4'(cds_pkg::MONTHS) && r_day >= 5'(cds_pkg::LONG_MONTH)) begin
                        r_day   <= 5'd1;
                        r_month <= 4'd1;
                        r_year  <= r_year + YEAR_BITS'(1);
                        if (r_year == MAX_YEAR || r_m400 == LAST_MOD) begin
                            r_m400 <= '0;
                        end else begin
                            r_m400 <= r_m400 + MB'(1);
                        end
                    end else if (r_day >= w_mdays_cur) begin
                        r_day   <= 5'd1;
                        r_month <= r_month + 4'd1;
                    end else begin
                        r_day <= r_day + 5'd1;
                    end
                end else begin
                    if (r_month <= 4'd1 && r_day <= 5'd1) begin
                        r_day   <= 5'(cds_pkg::LONG_MONTH);
                        r_month <= 4'(cds_pkg::MONTHS);
                        r_year  <= r_year - YEAR_BITS'(1);
                        if (r_year == '0) begin
                            r_m400 <= MAX_MOD;
                        end else if (r_m400 == '0) begin
                            r_m400 <= LAST_MOD;
                        end else begin
                            r_m400 <= r_m400 - MB'(1);
                        end
                    end else if (r_day <= 5'd1) begin
                        r_month <= w_month_prev;
                        r_day   <= w_mdays_prev;
                    end else begin
                        r_day <= r_day - 5'd1;
                    end
                end
            end
        end
    end

    // Command word latches, day counter and year reduction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_mul_done <= 1'b0;
        end else begin
            if (w_accept) begin
                r_back     <= i_day_delta[15];
                r_cnt      <= i_day_delta[15] ? 16'(16'd0 - i_day_delta) : i_day_delta;
                r_ld_day   <= i_in_day;
                r_ld_month <= w_ld_month;
                r_ld_year  <= w_in_year_ext[YEAR_BITS-1:0];
                r_mul_done <= 1'b0;
            end else begin
                // multiply by the reciprocal first, then take the remainder
                if (r_state == cds_pkg::ST_REDUCE) begin
                    if (!r_mul_done) begin
                        r_prod     <= w_prod;
                        r_mul_done <= 1'b1;
                    end else begin
                        r_rem <= w_m400;
                    end
                end
                if (r_state == cds_pkg::ST_STEP && r_cnt != 16'd0) begin
                    r_cnt <= r_cnt - 16'd1;
                end
            end
        end
    end

    // Checks
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !start |=> !o_valid)
        else $error("result strobe held past one cycle");

    a_date_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_month >= 4'd1 && r_month <= 4'(cds_pkg::MONTHS) && r_day >= 5'd1
        && r_day <= w_mdays_cur)
        else $error("stored date is not a calendar date");

    a_mod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m400 <= LAST_MOD)
        else $error("year remainder out of range");

    a_shift_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (w_func == cds_pkg::FUNC_SHIFT || w_func == cds_pkg::FUNC_LOAD) |=> busy)
        else $error("multi-cycle command did not raise busy");

    a_reduce_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == cds_pkg::ST_CLAMP |-> r_mul_done)
        else $error("load clamped before year reduction finished");

endmodule
